// ===== rtl/core/pix2x2_pkg.sv =====
// Shared widths, register indexes and the block record for the 2x2 pixelate core.
package pix2x2_pkg;

   // Pixel and coordinate widths
   localparam int CHAN_W  = 8;
   localparam int NUM_CH  = 4;
   localparam int PAIR_W  = CHAN_W + 1;
   localparam int SUM_W   = CHAN_W + 2;
   localparam int COORD_W = 11;
   localparam int LINE_W  = NUM_CH * PAIR_W;

   // Configuration port
   localparam int REG_W     = 12;
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;
   localparam logic [REG_W-1:0]     WIDTH_RESET      = 12'd640;
   localparam logic [REG_W-1:0]     HEIGHT_RESET     = 12'd480;

   // Stream payload widths
   localparam int REQ_TDATA_W = NUM_CH * CHAN_W;
   localparam int RSP_FIELD_W = 2 * COORD_W + NUM_CH * CHAN_W;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_FIELD_W;

   // Block queue
   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int LVL_W      = $clog2(FIFO_DEPTH + 1);

   // One finished block: coordinates of its bottom-right pixel and the averages
   typedef struct packed {
      logic [NUM_CH-1:0][CHAN_W-1:0] avg;
      logic [COORD_W-1:0]            y;
      logic [COORD_W-1:0]            x;
   } block_type;

endpackage

// ===== rtl/core/pix2x2_line_buf.sv =====
// Line buffer of horizontal pair sums: one write port, one registered read port.
module pix2x2_line_buf
   import pix2x2_pkg::*;
#(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [LINE_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [LINE_W-1:0] rd_data
);

   logic [LINE_W-1:0] mem_ff [DEPTH];
   logic [LINE_W-1:0] rd_data_ff;

   // Write pair sums on even rows
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read back on odd rows
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/pix2x2_out_seq.sv =====
// Block queue and result sequencer: each queued block leaves as four result items.
module pix2x2_out_seq
   import pix2x2_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  block_type              push_blk,
   output logic [LVL_W-1:0]       level,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // out_x, out_y, blue, green, red, alpha, pad
   output logic                   rsp_tlast    // last_of_block
);

   block_type              fifo_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [LVL_W-1:0]       count_ff, count_in;
   logic [1:0]             sub_ff, sub_in;
   logic                   valid_ff, valid_in;
   logic [RSP_TDATA_W-1:0] data_ff, data_in;
   logic                   last_ff, last_in;
   block_type              head;
   logic                   load;
   logic                   pop;

   assign head = fifo_ff[rd_ptr_ff];
   assign load = (count_ff != '0) && (!valid_ff || rsp_tready);
   assign pop  = load && (sub_ff == 2'd3);

   // Advance queue pointers and the sub-item counter
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + LVL_W'(push) - LVL_W'(pop);
      sub_in    = load ? sub_ff + 1'b1 : sub_ff;
   end

   // Form the next result item; x and y pick the corner of the block
   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = {{RSP_PAD_W{1'b0}}, head.avg,
                     head.y[COORD_W-1:1], sub_ff[1],
                     head.x[COORD_W-1:1], sub_ff[0]};
         last_in  = (sub_ff == 2'd3);
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         sub_ff    <= '0;
         valid_ff  <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         sub_ff    <= sub_in;
         valid_ff  <= valid_in;
      end
   end

   // Hold payload
   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= push_blk;
      end
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign level      = count_ff;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

endmodule

// ===== rtl/core/pixelate_2x2_block_average_core.sv =====
// Top level of the 2x2 block-average pixelate core.
//
// Input items on req_* are BGRA pixels in raster order, one pixel per item.
// For each aligned 2x2 block the core emits four result items on rsp_*, all
// carrying the truncated average of the four pixels, with the destination
// coordinates top-left, top-right, bottom-left, bottom-right; tlast marks
// the fourth. A trailing odd column or row is consumed with no result.
// csr_* sets image width (index 0) and height (index 1); clamped to
// 2..MAX_WIDTH and 2..MAX_HEIGHT. Write only while the core is idle.
// Throughput: one input item per cycle while req_tready is high and one
// result item per cycle while rsp_tready is high. A block's average passes
// the line buffer read and bottom pair registers, loaded on the edge that
// accepts its last pixel, then the block queue, then the result register.
// Odd rows make four results per two pixels; a four-block queue absorbs
// this, and when it fills req_tready drops, so the output port (one result
// per cycle) sets the pace of odd rows.
// Reset clears counters, the held left pixel, the queue and rsp_tvalid and
// loads width 640 and height 480. The line buffer is not cleared.
// When the receiver stalls, rsp_* holds its item and the queue fills
// before the input is stalled.
module pixelate_2x2_block_average_core
   import pix2x2_pkg::*;
#(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // blue_in, green_in, red_in, alpha_in
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // out_x, out_y, blue, green, red, alpha, pad
   output logic                   rsp_tlast,   // last_of_block
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_addr,
   input  logic [REG_W-1:0]       csr_wdata
);

   localparam int CW         = $clog2(MAX_WIDTH);
   localparam int RW         = $clog2(MAX_HEIGHT);
   localparam int DWX        = (CW + 1 > REG_W) ? CW + 1 : REG_W;
   localparam int DWY        = (RW + 1 > REG_W) ? RW + 1 : REG_W;
   localparam int LINE_DEPTH = (MAX_WIDTH / 2 > 0) ? MAX_WIDTH / 2 : 1;
   localparam int LAW        = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

   logic [REG_W-1:0]              width_ff, width_in;
   logic [REG_W-1:0]              height_ff, height_in;
   logic [CW-1:0]                 col_ff, col_in;
   logic [RW-1:0]                 row_ff, row_in;
   logic [NUM_CH-1:0][CHAN_W-1:0] left_ff, left_in;
   logic                          s1_valid_ff, s1_valid_in;
   logic [LINE_W-1:0]             s1_pair_ff;
   logic [COORD_W-1:0]            s1_x_ff;
   logic [COORD_W-1:0]            s1_y_ff;

   logic [DWX-1:0]                w_ext, w_lim, c_ext;
   logic [DWY-1:0]                h_ext, h_lim, r_ext;
   logic                          accept;
   logic                          in_area;
   logic                          col_odd;
   logic                          row_odd;
   logic [NUM_CH-1:0][CHAN_W-1:0] px;
   logic [LINE_W-1:0]             pair;
   logic [LAW-1:0]                line_idx;
   logic                          line_wr;
   logic                          line_rd;
   logic [LINE_W-1:0]             line_data;
   block_type                     blk;
   logic [LVL_W-1:0]              fifo_level;
   logic [LVL_W:0]                level_sum;

   // Take configuration writes
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_IMAGE_WIDTH:  width_in  = csr_wdata;
            CSR_IMAGE_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Clamp the frame size to the supported range
   always_comb begin
      w_ext = DWX'(width_ff);
      h_ext = DWY'(height_ff);
      if (w_ext < DWX'(2)) begin
         w_lim = DWX'(2);
      end else if (w_ext > DWX'(MAX_WIDTH)) begin
         w_lim = DWX'(MAX_WIDTH);
      end else begin
         w_lim = w_ext;
      end
      if (h_ext < DWY'(2)) begin
         h_lim = DWY'(2);
      end else if (h_ext > DWY'(MAX_HEIGHT)) begin
         h_lim = DWY'(MAX_HEIGHT);
      end else begin
         h_lim = h_ext;
      end
   end

   // Decode the position of the incoming pixel
   assign accept   = req_tvalid && req_tready;
   assign c_ext    = DWX'(col_ff);
   assign r_ext    = DWY'(row_ff);
   assign in_area  = (c_ext < {w_lim[DWX-1:1], 1'b0}) && (r_ext < {h_lim[DWY-1:1], 1'b0});
   assign col_odd  = col_ff[0];
   assign row_odd  = row_ff[0];
   assign px       = req_tdata;
   assign line_idx = LAW'(col_ff >> 1);

   // Sum the held left pixel with the current one, per channel
   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         pair[ch*PAIR_W +: PAIR_W] = PAIR_W'(left_ff[ch]) + PAIR_W'(px[ch]);
      end
   end

   // Advance column and row counters; hold the left pixel of each pair
   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      left_in     = left_ff;
      s1_valid_in = accept && in_area && col_odd && row_odd;
      if (accept) begin
         if (in_area && !col_odd) begin
            left_in = px;
         end
         if (c_ext + DWX'(1) >= w_lim) begin
            col_in = '0;
            row_in = (r_ext + DWY'(1) >= h_lim) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   assign line_wr = accept && in_area && col_odd && !row_odd;
   assign line_rd = s1_valid_in;

   pix2x2_line_buf #(
      .DEPTH (LINE_DEPTH),
      .AW    (LAW)
   ) u_line_buf (
      .clock   (clock),
      .wr_en   (line_wr),
      .wr_addr (line_idx),
      .wr_data (pair),
      .rd_en   (line_rd),
      .rd_addr (line_idx),
      .rd_data (line_data)
   );

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= WIDTH_RESET;
         height_ff   <= HEIGHT_RESET;
         col_ff      <= '0;
         row_ff      <= '0;
         left_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         left_ff     <= left_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Hold the bottom pair sum and block corner for the average stage
   always_ff @(posedge clock) begin
      if (s1_valid_in) begin
         s1_pair_ff <= pair;
         s1_x_ff    <= COORD_W'(col_ff);
         s1_y_ff    <= COORD_W'(row_ff);
      end
   end

   // Add the top pair sum and drop the two low bits
   always_comb begin
      logic [SUM_W-1:0] sum;
      blk.x = s1_x_ff;
      blk.y = s1_y_ff;
      for (int ch = 0; ch < NUM_CH; ch++) begin
         sum = SUM_W'(line_data[ch*PAIR_W +: PAIR_W]) + SUM_W'(s1_pair_ff[ch*PAIR_W +: PAIR_W]);
         blk.avg[ch] = sum[SUM_W-1:2];
      end
   end

   pix2x2_out_seq u_out_seq (
      .clock      (clock),
      .reset      (reset),
      .push       (s1_valid_ff),
      .push_blk   (blk),
      .level      (fifo_level),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // Accept only while the queue has room for the block in flight and one more
   assign level_sum  = {1'b0, fifo_level} + {{LVL_W{1'b0}}, s1_valid_ff};
   assign req_tready = level_sum < (LVL_W + 1)'(FIFO_DEPTH);

endmodule

// ===== rtl/core/pix2x2_checker.sv =====
// Port checker for the 2x2 pixelate core, bound to its top level.
module pix2x2_checker
   import pix2x2_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic                   rsp_tlast
);

   // A stalled result item keeps its coordinates and marker
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata[2*COORD_W-1:0])
         && $stable(rsp_tlast))
      else $error("stalled result item changed");

   // The marked item is the bottom-right pixel of its block
   a_last_corner: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[0] && rsp_tdata[COORD_W])
      else $error("last item of block not at odd column and odd row");

   // Unmarked items are never the bottom-right pixel
   a_other_corner: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !(rsp_tdata[0] && rsp_tdata[COORD_W]))
      else $error("bottom-right pixel of block not marked last");

   // Reset empties the result port
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind pixelate_2x2_block_average_core pix2x2_checker u_pix2x2_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the 2x2 block-average pixelate core.
module tb_top
   import pix2x2_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_W          = 2048;
   localparam int MAX_H          = 2048;
   localparam int LINE_DEPTH     = MAX_W / 2;
   localparam int SETTLE_CYCLES  = 12;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS   = 110;
   localparam int WIDE_ITEMS     = 32;
   localparam int MAX_REPORTS    = 10;

   // One output pixel of a finished block
   typedef struct packed {
      logic [COORD_W-1:0]            x;
      logic [COORD_W-1:0]            y;
      logic [NUM_CH-1:0][CHAN_W-1:0] avg;
      logic                          last;
   } out_pixel_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;   // blue_in, green_in, red_in, alpha_in
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;         // out_x, out_y, blue, green, red, alpha, pad
   logic                   rsp_tlast;         // last_of_block
   logic                   csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_addr   = '0;
   logic [REG_W-1:0]       csr_wdata  = '0;

   pixelate_2x2_block_average_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // Pending pixels and expected output pixels
   logic [REQ_TDATA_W-1:0] pixel_q [$];
   out_pixel_type          block_avg_q [$];

   // Shadow of the core: registers, counters, held pixel and pair-sum line
   logic [REG_W-1:0]                   width_cfg  = WIDTH_RESET;
   logic [REG_W-1:0]                   height_cfg = HEIGHT_RESET;
   int unsigned                        pred_col   = 0;
   int unsigned                        pred_row   = 0;
   logic [NUM_CH-1:0][CHAN_W-1:0]      left_hold  = '0;
   logic [NUM_CH-1:0][PAIR_W-1:0]      pair_line [LINE_DEPTH];

   int unsigned mismatch_count = 0;
   int unsigned random_count   = 0;
   int unsigned send_gap       = 0;
   int unsigned stall_left     = 0;
   int unsigned quiet_cycles   = 0;
   bit          send_quiet     = 1'b0;
   bit          drain_quiet    = 1'b0;

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int unsigned clamp_dim(input logic [REG_W-1:0] v,
                                             input int unsigned maxv);
      if (v < 2) return 2;
      if (v > maxv) return maxv;
      return 32'(v);
   endfunction

   // Mostly short gaps, a few long ones; none while in a quiet stretch
   function automatic int unsigned pick_idle(input bit quiet);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [CHAN_W-1:0] pick_channel();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return CHAN_W'($urandom_range(0, 255));
      endcase
   endfunction

   // Advance the shadow by one accepted pixel and queue any block output
   task automatic predict_block_avg(input logic [REQ_TDATA_W-1:0] data);
      int unsigned                   w, h, idx;
      logic [NUM_CH-1:0][CHAN_W-1:0] px, avg;
      logic [SUM_W-1:0]              sum;
      out_pixel_type                 item;
      w   = clamp_dim(width_cfg, MAX_W);
      h   = clamp_dim(height_cfg, MAX_H);
      px  = data;
      idx = pred_col / 2;
      if (pred_col < (w / 2) * 2 && pred_row < (h / 2) * 2) begin
         if (pred_col % 2 == 0) begin
            left_hold = px;
         end else if (pred_row % 2 == 0) begin
            for (int k = 0; k < NUM_CH; k++)
               pair_line[idx][k] = PAIR_W'(left_hold[k]) + PAIR_W'(px[k]);
         end else begin
            for (int k = 0; k < NUM_CH; k++) begin
               sum = SUM_W'(pair_line[idx][k]) + SUM_W'(left_hold[k]) + SUM_W'(px[k]);
               avg[k] = CHAN_W'(sum >> 2);
            end
            // Top-left, top-right, bottom-left, bottom-right
            for (int k = 0; k < 4; k++) begin
               item.x    = COORD_W'((k % 2 == 1) ? pred_col : pred_col - 1);
               item.y    = COORD_W'((k / 2 == 1) ? pred_row : pred_row - 1);
               item.avg  = avg;
               item.last = (k == 3);
               block_avg_q.push_back(item);
            end
         end
      end
      if (pred_col + 1 >= w) begin
         pred_col = 0;
         pred_row = (pred_row + 1 >= h) ? 0 : pred_row + 1;
      end else begin
         pred_col = pred_col + 1;
      end
   endtask

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t ns: %s", $realtime, what);
   endtask

   // Compare one output item with the oldest expected pixel
   task automatic check_block_avg();
      out_pixel_type got, want;
      bit            bad;
      got.x    = rsp_tdata[COORD_W-1:0];
      got.y    = rsp_tdata[2*COORD_W-1:COORD_W];
      got.avg  = rsp_tdata[2*COORD_W +: NUM_CH*CHAN_W];
      got.last = rsp_tlast;
      if (block_avg_q.size() == 0) begin
         report_mismatch($sformatf("unexpected item x=%0d y=%0d bgra=%h last=%0d",
                                   got.x, got.y, got.avg, got.last));
         return;
      end
      want = block_avg_q.pop_front();
      bad  = (got.x !== want.x) || (got.y !== want.y) || (got.last !== want.last);
      for (int k = 0; k < NUM_CH; k++)
         if (got.avg[k] !== want.avg[k]) bad = 1'b1;
      if (bad)
         report_mismatch($sformatf(
            "mismatch: expected x=%0d y=%0d bgra=%h last=%0d, got x=%0d y=%0d bgra=%h last=%0d",
            want.x, want.y, want.avg, want.last, got.x, got.y, got.avg, got.last));
   endtask

   // Input driver: pop pending pixels, insert random gaps, feed the shadow
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap   <= 0;
      end else begin
         if (req_tvalid && req_tready)
            predict_block_avg(req_tdata);
         if (!req_tvalid || req_tready) begin
            if (send_gap != 0) begin
               req_tvalid <= 1'b0;
               send_gap   <= send_gap - 1;
            end else if (pixel_q.size() == 0) begin
               req_tvalid <= 1'b0;
            end else begin
               req_tvalid <= 1'b1;
               req_tdata  <= pixel_q.pop_front();
               send_gap   <= pick_idle(send_quiet);
            end
         end
         if ($urandom_range(0, 63) == 0)
            send_quiet <= !send_quiet;
      end
   end

   // Output monitor: check accepted items, stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_block_avg();
         if (stall_left != 0) begin
            rsp_tready <= 1'b0;
            stall_left <= stall_left - 1;
         end else if (!drain_quiet && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            stall_left <= pick_idle(1'b0);
         end else begin
            rsp_tready <= 1'b1;
         end
         if ($urandom_range(0, 199) == 0)
            drain_quiet <= !drain_quiet;
      end
   end

   // Watchdog: end the run when no item moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] addr, input logic [REG_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (addr == CSR_IMAGE_WIDTH)
         width_cfg = value;
      else
         height_cfg = value;
   endtask

   // Wait until every pixel is taken and every output pixel has come, then settle
   task automatic drain_pipe();
      while (pixel_q.size() != 0 || req_tvalid || block_avg_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic push_pixel(input logic [CHAN_W-1:0] b, g, r, a);
      pixel_q.push_back({a, r, g, b});
   endtask

   task automatic push_items(input int unsigned count);
      repeat (count) begin
         push_pixel(pick_channel(), pick_channel(), pick_channel(), pick_channel());
         random_count++;
      end
   endtask

   task automatic push_rows(input int unsigned rows);
      int unsigned w;
      w = clamp_dim(width_cfg, MAX_W);
      push_items(rows * w);
   endtask

   // Finish the odd row if needed so the line buffer stays valid, then reconfigure
   task automatic start_phase(input logic [REG_W-1:0] wv, input logic [REG_W-1:0] hv);
      drain_pipe();
      if (pred_row % 2 != 0) begin
         push_rows(1);
         drain_pipe();
      end
      write_reg(CSR_IMAGE_WIDTH, wv);
      write_reg(CSR_IMAGE_HEIGHT, hv);
   endtask

   function automatic logic [REG_W-1:0] pick_width();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) return REG_W'($urandom_range(0, 1));
      if (roll < 85) return REG_W'($urandom_range(2, 16));
      return REG_W'($urandom_range(17, 64));
   endfunction

   function automatic logic [REG_W-1:0] pick_height();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 15) return REG_W'($urandom_range(0, 1));
      if (roll < 75) return REG_W'($urandom_range(2, 9));
      if (roll < 90) return REG_W'($urandom_range(10, 2048));
      return REG_W'($urandom_range(2049, 4095));
   endfunction

   // Stimulus
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Smallest frame: registers below range act as 2x2
      start_phase('0, REG_W'(1));
      repeat (4) push_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
      repeat (4) push_pixel(8'h00, 8'h00, 8'h00, 8'h00);
      // Truncation of the divide by four
      push_pixel(8'd3, 8'd255, 8'd1, 8'd254);
      push_pixel(8'd0, 8'd255, 8'd1, 8'd255);
      push_pixel(8'd0, 8'd255, 8'd1, 8'd255);
      push_pixel(8'd0, 8'd254, 8'd0, 8'd255);

      // Odd size: trailing column and row give no output
      start_phase(REG_W'(3), REG_W'(3));
      push_rows(3);

      // Width above range clamps; start a wide row, then narrow the width
      // mid-row so the column counter stands at the limit and wraps
      start_phase('1, REG_W'(MAX_H));
      push_items(WIDE_ITEMS);
      drain_pipe();
      write_reg(CSR_IMAGE_WIDTH, REG_W'(WIDE_ITEMS));
      push_items(WIDE_ITEMS + 1);

      // Random sizes, changed at even row starts, often mid-frame
      random_count = 0;
      while (random_count < RANDOM_ITEMS) begin
         start_phase(pick_width(), pick_height());
         push_rows($urandom_range(1, 5));
      end

      drain_pipe();
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/pix2x2_pkg.sv
rtl/core/pix2x2_line_buf.sv
rtl/core/pix2x2_out_seq.sv
rtl/core/pixelate_2x2_block_average_core.sv
rtl/core/pix2x2_checker.sv
tb/tb_top.sv
